// File: rtl/core/gms_pkg.sv
`default_nettype none

package gms_pkg;

   // counter and register widths
   localparam int CW    = 24;
   localparam int CFG_W = 24;
   localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W;

   typedef logic [CW-1:0]    count_type;
   typedef logic [CMP_W-1:0] cmp_type;
   typedef logic [CFG_W-1:0] cfg_word_type;

   localparam count_type CNT_MAX = '1;

   // beat widths on the stream ports
   localparam int REQ_FIELDS_W = 13;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_FIELDS_W = 6;
   localparam int RSP_DATA_W   = 8;

   // command characters
   localparam logic [7:0] CMD_SHORT_OPEN = 8'h57; // W
   localparam logic [7:0] CMD_FULL_OPEN  = 8'h43; // C
   localparam logic [7:0] CMD_LIGHT      = 8'h4C; // L
   localparam logic [7:0] CMD_BUZZER     = 8'h42; // B
   localparam logic [7:0] CMD_CLOSE      = 8'h58; // X

   // register file
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   typedef enum logic [1:0] {
      CSR_SETTLE     = 2'd0,
      CSR_PAUSE      = 2'd1,
      CSR_SHORT_OPEN = 2'd2,
      CSR_BLINK      = 2'd3
   } csr_reg_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_SETTLE = 2'd1,
      PH_DRIVE  = 2'd2,
      PH_PAUSE  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CLOSE = 2'd0,
      KIND_FULL  = 2'd1,
      KIND_SHORT = 2'd2
   } kind_type;

   // one tick beat, first field in the highest bits
   typedef struct packed {
      logic [7:0] cmd_byte;
      logic       cmd_valid;
      logic       close_button;
      logic       open_button;
      logic       limit_closed;
      logic       limit_open;
   } tick_type;

   typedef struct packed {
      logic busy_res;
      logic buzzer_out;
      logic beacon;
      logic drive_close;
      logic drive_open;
      logic motor_on;
   } result_type;

   typedef struct packed {
      cfg_word_type settle_ticks;
      cfg_word_type pause_ticks;
      cfg_word_type short_open_ticks;
      cfg_word_type blink_ticks;
   } cfg_type;

   // saturating increment
   function automatic count_type bump(input count_type c);
      return (c == CNT_MAX) ? c : c + count_type'(1);
   endfunction

   // effective tick count: zero acts as one, clamp to the counter range
   function automatic cmp_type lim(input cfg_word_type v);
      cmp_type x;
      x = cmp_type'(v);
      if (x == cmp_type'(0)) begin
         x = cmp_type'(1);
      end
      if (x > cmp_type'(CNT_MAX)) begin
         x = cmp_type'(CNT_MAX);
      end
      return x;
   endfunction

   function automatic logic reached(input count_type c, input cfg_word_type v);
      return cmp_type'(c) >= lim(v);
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/gate_motor_sequencer.sv
// Gate motor sequencer.
// Input stream req_*: one beat per tick with the limit switches, the two
// buttons and an optional command byte. Output stream rsp_*: one beat per
// tick with the motor, direction, beacon, buzzer and busy levels after it.
// Configuration through the csr_* port: settle, pause, short-open and blink
// tick counts at byte addresses 0, 4, 8 and 12; write only while idle.
// Path: a tick beat is captured in the input register and, once the result
// slot is free, stepped into the result register. Throughput: one beat per
// clock while rsp_tready stays high, set by the state update between the
// input register and the result register.
// Reset (synchronous) loads the default tick counts and starts the
// power-up close motion at its settle wait; both streams come up empty.
// When rsp_tready is low, the result beat is held, one more tick beat is
// taken into the input register, and then req_tready drops until the
// result beat is taken.
`default_nettype none

module gate_motor_sequencer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // bit 0 limit_open, 1 limit_closed, 2 open_button, 3 close_button,
   // 4 cmd_valid, 12:5 cmd_byte, 15:13 zero
   input  wire logic [gms_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // bit 0 motor_on, 1 drive_open, 2 drive_close, 3 beacon, 4 buzzer_out,
   // 5 busy_res, 7:6 zero
   output logic      [gms_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [gms_pkg::CSR_AW-1:0]        csr_paddr,
   input  wire logic [gms_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic      [gms_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                                   csr_pready
);
   import gms_pkg::*;

   logic       req_valid_ff, req_valid_in;
   tick_type   req_tick_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   logic       out_free, step_en;
   cfg_type    cfg;
   result_type result;

   gms_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gms_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .tick    (req_tick_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // handshake: step when a tick is held and the result slot is free
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step_en    = req_valid_ff && out_free;
   assign req_tready = !req_valid_ff || step_en;

   assign req_valid_in = (req_tvalid && req_tready) ? 1'b1 : (step_en ? 1'b0 : req_valid_ff);
   assign rsp_valid_in = step_en ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // capture the tick beat
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_tick_ff <= tick_type'(req_tdata[REQ_FIELDS_W-1:0]);
      end
   end

   // hold the result beat
   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

endmodule

`default_nettype wire

// File: rtl/core/gms_csr.sv
`default_nettype none

module gms_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [gms_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [gms_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic      [gms_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                             csr_pready,
   output gms_pkg::cfg_type                 cfg
);
   import gms_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        wr_en;
   csr_reg_type reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_reg_type'(csr_paddr[3:2]);

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            CSR_SETTLE:     cfg_in.settle_ticks     = csr_pwdata[CFG_W-1:0];
            CSR_PAUSE:      cfg_in.pause_ticks      = csr_pwdata[CFG_W-1:0];
            CSR_SHORT_OPEN: cfg_in.short_open_ticks = csr_pwdata[CFG_W-1:0];
            CSR_BLINK:      cfg_in.blink_ticks      = csr_pwdata[CFG_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ticks     <= cfg_word_type'(1000);
         cfg_ff.pause_ticks      <= cfg_word_type'(500);
         cfg_ff.short_open_ticks <= cfg_word_type'(1000);
         cfg_ff.blink_ticks      <= cfg_word_type'(250);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_sel)
         CSR_SETTLE:     csr_prdata = CSR_DW'(cfg_ff.settle_ticks);
         CSR_PAUSE:      csr_prdata = CSR_DW'(cfg_ff.pause_ticks);
         CSR_SHORT_OPEN: csr_prdata = CSR_DW'(cfg_ff.short_open_ticks);
         CSR_BLINK:      csr_prdata = CSR_DW'(cfg_ff.blink_ticks);
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/core/gms_seq.sv
`default_nettype none

module gms_seq (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step_en,
   input  wire gms_pkg::tick_type tick,
   input  wire gms_pkg::cfg_type  cfg,
   output gms_pkg::result_type result
);
   import gms_pkg::*;

   phase_type phase_ff, phase_in;
   kind_type  kind_ff, kind_in;
   count_type phase_count_ff, phase_count_in;
   count_type blink_count_ff, blink_count_in;
   logic      motor_ff, motor_in;
   logic      dir_open_ff, dir_open_in;
   logic      dir_close_ff, dir_close_in;
   logic      beacon_ff, beacon_in;
   logic      buzzer_ff, buzzer_in;

   logic      cmd_short, cmd_full, cmd_close, cmd_light, cmd_buzz;
   logic      start, at_end, stop;
   kind_type  start_kind;
   count_type pc_bump, bc_bump;

   // idle command and button decode
   assign cmd_short = tick.cmd_valid && (tick.cmd_byte == CMD_SHORT_OPEN);
   assign cmd_full  = tick.cmd_valid && (tick.cmd_byte == CMD_FULL_OPEN);
   assign cmd_close = tick.cmd_valid && (tick.cmd_byte == CMD_CLOSE);
   assign cmd_light = tick.cmd_valid && (tick.cmd_byte == CMD_LIGHT);
   assign cmd_buzz  = tick.cmd_valid && (tick.cmd_byte == CMD_BUZZER);
   assign start     = cmd_short | cmd_full | cmd_close | tick.open_button | tick.close_button;

   always_comb begin
      if (cmd_short) begin
         start_kind = KIND_SHORT;
      end else if (cmd_full) begin
         start_kind = KIND_FULL;
      end else if (cmd_close) begin
         start_kind = KIND_CLOSE;
      end else if (tick.open_button) begin
         start_kind = KIND_FULL;
      end else begin
         start_kind = KIND_CLOSE;
      end
   end

   // drive end condition
   assign at_end = (kind_ff == KIND_CLOSE) ? tick.limit_closed : tick.limit_open;
   assign stop   = at_end | tick.open_button | tick.close_button |
                   ((kind_ff == KIND_SHORT) && reached(phase_count_ff, cfg.short_open_ticks));

   assign pc_bump = bump(phase_count_ff);
   assign bc_bump = bump(blink_count_ff);

   // next phase and motion kind
   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               phase_in = PH_SETTLE;
               kind_in  = start_kind;
            end
         end
         PH_SETTLE: begin
            if (reached(pc_bump, cfg.settle_ticks)) begin
               phase_in = PH_DRIVE;
            end
         end
         PH_DRIVE: begin
            if (stop) begin
               phase_in = PH_PAUSE;
            end
         end
         PH_PAUSE: begin
            if (reached(pc_bump, cfg.pause_ticks)) begin
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = phase_ff;
      endcase
   end

   // counters and output levels
   always_comb begin
      phase_count_in = phase_count_ff;
      blink_count_in = blink_count_ff;
      motor_in       = motor_ff;
      dir_open_in    = dir_open_ff;
      dir_close_in   = dir_close_ff;
      beacon_in      = beacon_ff;
      buzzer_in      = buzzer_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            // light and buzzer toggles still apply when a button starts a motion
            beacon_in = beacon_ff ^ cmd_light;
            buzzer_in = buzzer_ff ^ cmd_buzz;
            if (start) begin
               phase_count_in = '0;
               blink_count_in = '0;
            end
         end
         PH_SETTLE: begin
            if (reached(pc_bump, cfg.settle_ticks)) begin
               phase_count_in = '0;
               blink_count_in = '0;
            end else begin
               phase_count_in = pc_bump;
            end
         end
         PH_DRIVE: begin
            if (stop) begin
               motor_in       = 1'b0;
               beacon_in      = 1'b0;
               buzzer_in      = 1'b0;
               phase_count_in = '0;
            end else begin
               motor_in       = 1'b1;
               dir_open_in    = (kind_ff != KIND_CLOSE);
               dir_close_in   = (kind_ff == KIND_CLOSE);
               phase_count_in = pc_bump;
               if (reached(bc_bump, cfg.blink_ticks)) begin
                  beacon_in      = ~beacon_ff;
                  buzzer_in      = ~buzzer_ff;
                  blink_count_in = '0;
               end else begin
                  blink_count_in = bc_bump;
               end
            end
         end
         PH_PAUSE: begin
            if (reached(pc_bump, cfg.pause_ticks)) begin
               phase_count_in = '0;
            end else begin
               phase_count_in = pc_bump;
            end
         end
         default: phase_count_in = phase_count_ff;
      endcase
   end

   // state advances once per tick beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SETTLE;
         kind_ff        <= KIND_CLOSE;
         phase_count_ff <= '0;
         blink_count_ff <= '0;
         motor_ff       <= 1'b0;
         dir_open_ff    <= 1'b0;
         dir_close_ff   <= 1'b0;
         beacon_ff      <= 1'b0;
         buzzer_ff      <= 1'b0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         kind_ff        <= kind_in;
         phase_count_ff <= phase_count_in;
         blink_count_ff <= blink_count_in;
         motor_ff       <= motor_in;
         dir_open_ff    <= dir_open_in;
         dir_close_ff   <= dir_close_in;
         beacon_ff      <= beacon_in;
         buzzer_ff      <= buzzer_in;
      end
   end

   // levels after this tick
   assign result.motor_on    = motor_in;
   assign result.drive_open  = dir_open_in;
   assign result.drive_close = dir_close_in;
   assign result.beacon      = beacon_in;
   assign result.buzzer_out  = buzzer_in;
   assign result.busy_res    = (phase_in != PH_IDLE);

endmodule

`default_nettype wire

// File: rtl/core/gms_checker.sv
`default_nettype none

module gms_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [gms_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import gms_pkg::*;

   // a stalled result beat holds its levels
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // both streams come up empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("stream not empty after reset");

   // input back-pressure only while a result beat is stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a stalled result");

   // the motor runs only within a motion
   a_motor_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[5])
      else $error("motor on while idle");

   // never both directions at once
   a_dir_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[1] && rsp_tdata[2]))
      else $error("both direction lines high");

endmodule

bind gate_motor_sequencer gms_checker u_gms_checker (.*);

`default_nettype wire
